// ===== design/ece_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ece_pkg;

   localparam int TIME_BITS_DEF = 16;

   // signed Q4.30 (34-bit) working format for progress and curve values
   localparam int QB         = 30;
   localparam int QW         = 34;
   localparam int PW         = 2 * QW;
   localparam int EW         = QW + 2;
   localparam int QUO_BITS   = 32;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = QUO_BITS / DIV_STEPS;
   localparam int MODE_W     = 4;
   localparam int CHG_W      = 31;
   localparam int OFS_W      = 32;

   typedef logic signed [QW-1:0] qval_type;
   typedef logic signed [EW-1:0] ewide_type;

   localparam qval_type Q_ONE   = 34'sd1073741824;
   localparam qval_type Q_TWO   = 34'sd2147483648;
   localparam qval_type Q_THREE = 34'sd3221225472;
   localparam qval_type S_BACK  = 34'sd1827057613;
   localparam qval_type S_BACK2 = 34'sd2786262860;

   // bounce segments, in units of eleven times progress
   localparam ewide_type B_EDGE1 = 36'sd4294967296;
   localparam ewide_type B_EDGE2 = 36'sd8589934592;
   localparam ewide_type B_EDGE3 = 36'sd10737418240;
   localparam ewide_type B_MID2  = 36'sd6442450944;
   localparam ewide_type B_MID3  = 36'sd9663676416;
   localparam ewide_type B_MID4  = 36'sd11274289152;
   localparam qval_type  B_LIFT2 = 34'sd805306368;
   localparam qval_type  B_LIFT3 = 34'sd1006632960;
   localparam qval_type  B_LIFT4 = 34'sd1056964608;

   typedef enum logic [MODE_W-1:0] {
      MD_LINEAR       = 4'd0,
      MD_BACK_IN      = 4'd1,
      MD_BACK_OUT     = 4'd2,
      MD_BACK_INOUT   = 4'd3,
      MD_BOUNCE_IN    = 4'd4,
      MD_BOUNCE_OUT   = 4'd5,
      MD_BOUNCE_INOUT = 4'd6,
      MD_QUAD_IN      = 4'd7,
      MD_QUAD_OUT     = 4'd8,
      MD_QUAD_INOUT   = 4'd9,
      MD_QUINT_IN     = 4'd10,
      MD_QUINT_OUT    = 4'd11,
      MD_QUINT_INOUT  = 4'd12
   } mode_type;

   typedef struct packed {
      logic [MODE_W-1:0]       func;
      logic                    first;
      logic                    zero_dur;
      logic signed [CHG_W-1:0] change;
   } item_ctl_type;

   typedef struct packed {
      logic       shift34;
      logic       mul2;
      logic       sq2;
      logic       mul3;
      logic       inv;
      logic [1:0] off;
      logic       halve;
   } crv_ctl_type;

endpackage
`default_nettype wire

// ===== design/ece_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ece_req_if #(parameter int TIME_BITS = ece_pkg::TIME_BITS_DEF);
   logic                    valid;
   logic                    ready;
   logic [3:0]              func;
   logic [TIME_BITS-1:0]    elapsed;
   logic [TIME_BITS-1:0]    duration;
   logic signed [30:0]      change;

   modport source(output valid, output func, output elapsed, output duration,
                  output change, input ready);
   modport sink(input valid, input func, input elapsed, input duration,
                input change, output ready);
endinterface
`default_nettype wire

// ===== design/ece_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ece_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] offset;
   logic               bad_mode;
   logic               zero_duration;

   modport source(output valid, output offset, output bad_mode,
                  output zero_duration, input ready);
   modport sink(input valid, input offset, input bad_mode,
                input zero_duration, output ready);
endinterface
`default_nettype wire

// ===== design/ece_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ece_div_stage #(
   parameter int TIME_BITS = ece_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           valid_i,
   input  ece_pkg::item_ctl_type          ctl_i,
   input  logic [TIME_BITS:0]             rem_i,
   input  logic [TIME_BITS-1:0]           den_i,
   input  logic [ece_pkg::QUO_BITS-1:0]   quo_i,
   output logic                           valid_o,
   output ece_pkg::item_ctl_type          ctl_o,
   output logic [TIME_BITS:0]             rem_o,
   output logic [TIME_BITS-1:0]           den_o,
   output logic [ece_pkg::QUO_BITS-1:0]   quo_o
);
   import ece_pkg::*;

   logic                  valid_ff;
   item_ctl_type          ctl_ff;
   logic [TIME_BITS:0]    rem_ff, rem_in;
   logic [TIME_BITS-1:0]  den_ff;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;

   // restoring division, one quotient bit per step
   always_comb begin
      rem_in = rem_i;
      quo_in = quo_i;
      for (int i = 0; i < DIV_STEPS; i++) begin
         if (rem_in >= {1'b0, den_i}) begin
            rem_in = rem_in - {1'b0, den_i};
            quo_in = {quo_in[QUO_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[QUO_BITS-2:0], 1'b0};
         end
         rem_in = {rem_in[TIME_BITS-1:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= ctl_i;
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
      end
   end

   assign valid_o = valid_ff;
   assign ctl_o   = ctl_ff;
   assign rem_o   = rem_ff;
   assign den_o   = den_ff;
   assign quo_o   = quo_ff;
endmodule
`default_nettype wire

// ===== design/ece_curve.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ece_curve (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          valid_i,
   input  ece_pkg::item_ctl_type         ctl_i,
   input  logic [ece_pkg::QUO_BITS-1:0]  quo_i,
   output logic                          valid_o,
   output ece_pkg::item_ctl_type         ctl_o,
   output ece_pkg::qval_type             f_o
);
   import ece_pkg::*;

   // stage 0: operand setup
   logic          vld0_ff;
   item_ctl_type  ictl0_ff;
   crv_ctl_type   cc0_ff, cc0_in;
   qval_type      opa0_ff, opa0_in, opb0_ff, opb0_in;
   qval_type      u0_ff, u0_in, kadd0_ff, kadd0_in;
   // stage 1: first products
   logic          vld1_ff;
   item_ctl_type  ictl1_ff;
   crv_ctl_type   cc1_ff;
   qval_type      u1_ff, a1_ff, a1_in, b1_ff, b1_in;
   // stage 2: second product
   logic          vld2_ff;
   item_ctl_type  ictl2_ff;
   crv_ctl_type   cc2_ff;
   qval_type      u2_ff, c2_ff, c2_in;
   // stage 3: third product
   logic          vld3_ff;
   item_ctl_type  ictl3_ff;
   crv_ctl_type   cc3_ff;
   qval_type      d3_ff, d3_in;
   // stage 4: fold halves and offsets
   logic          vld4_ff;
   item_ctl_type  ictl4_ff;
   qval_type      f4_ff, f4_in;

   logic signed [PW-1:0] prod_a, prod_b, prod_2, prod_3;
   qval_type             sel2, dterm, offq;

   always_comb begin
      qval_type  xs, ps, bv;
      ewide_type e, q, a;
      logic      bounce;
      xs     = qval_type'({2'b00, quo_i});
      ps     = qval_type'({3'b000, quo_i[QUO_BITS-1:1]});
      bv     = '0;
      bounce = 1'b0;
      cc0_in   = '0;
      opa0_in  = ps;
      opb0_in  = Q_ONE;
      u0_in    = '0;
      kadd0_in = '0;
      case (mode_type'(ctl_i.func))
         MD_BACK_IN: begin
            u0_in = ps; opa0_in = S_BACK + Q_ONE; opb0_in = ps;
            kadd0_in = -S_BACK; cc0_in.mul2 = 1'b1;
         end
         MD_BACK_OUT: begin
            u0_in = ps - Q_ONE; opa0_in = S_BACK + Q_ONE; opb0_in = ps - Q_ONE;
            kadd0_in = S_BACK; cc0_in.mul2 = 1'b1; cc0_in.off = 2'd1;
         end
         MD_BACK_INOUT: begin
            opa0_in = S_BACK2 + Q_ONE; cc0_in.mul2 = 1'b1; cc0_in.halve = 1'b1;
            if (ctl_i.first) begin
               u0_in = xs; opb0_in = xs; kadd0_in = -S_BACK2;
            end else begin
               u0_in = xs - Q_TWO; opb0_in = xs - Q_TWO; kadd0_in = S_BACK2;
               cc0_in.off = 2'd2;
            end
         end
         MD_BOUNCE_IN: begin
            bounce = 1'b1; bv = Q_ONE - ps; cc0_in.inv = 1'b1;
         end
         MD_BOUNCE_OUT: begin
            bounce = 1'b1; bv = ps;
         end
         MD_BOUNCE_INOUT: begin
            bounce = 1'b1; cc0_in.halve = 1'b1;
            if (ctl_i.first) begin
               bv = Q_ONE - xs; cc0_in.inv = 1'b1;
            end else begin
               bv = xs - Q_ONE; cc0_in.off = 2'd1;
            end
         end
         MD_QUAD_IN: begin
            opa0_in = ps; opb0_in = ps;
         end
         MD_QUAD_OUT: begin
            opa0_in = ps; opb0_in = Q_TWO - ps;
         end
         MD_QUAD_INOUT: begin
            cc0_in.halve = 1'b1;
            if (ctl_i.first) begin
               opa0_in = xs; opb0_in = xs;
            end else begin
               opa0_in = xs - Q_ONE; opb0_in = Q_THREE - xs; cc0_in.off = 2'd1;
            end
         end
         MD_QUINT_IN: begin
            u0_in = ps;
            cc0_in.mul2 = 1'b1; cc0_in.sq2 = 1'b1; cc0_in.mul3 = 1'b1;
         end
         MD_QUINT_OUT: begin
            u0_in = ps - Q_ONE; cc0_in.off = 2'd1;
            cc0_in.mul2 = 1'b1; cc0_in.sq2 = 1'b1; cc0_in.mul3 = 1'b1;
         end
         MD_QUINT_INOUT: begin
            cc0_in.halve = 1'b1;
            cc0_in.mul2 = 1'b1; cc0_in.sq2 = 1'b1; cc0_in.mul3 = 1'b1;
            if (ctl_i.first) begin
               u0_in = xs;
            end else begin
               u0_in = xs - Q_TWO; cc0_in.off = 2'd2;
            end
         end
         default: begin
         end
      endcase
      // bounce: pick the parabola segment and square its distance
      e = (EW'(bv) <<< 3) + (EW'(bv) <<< 1) + EW'(bv);
      if (e < B_EDGE1) begin
         q = e; kadd0_in = bounce ? '0 : kadd0_in;
      end else if (e < B_EDGE2) begin
         q = e - B_MID2; kadd0_in = bounce ? B_LIFT2 : kadd0_in;
      end else if (e < B_EDGE3) begin
         q = e - B_MID3; kadd0_in = bounce ? B_LIFT3 : kadd0_in;
      end else begin
         q = e - B_MID4; kadd0_in = bounce ? B_LIFT4 : kadd0_in;
      end
      a = (q < 0) ? -q : q;
      if (bounce) begin
         opa0_in = a[QW-1:0];
         opb0_in = a[QW-1:0];
         cc0_in.shift34 = 1'b1;
      end
   end

   assign prod_a = opa0_ff * opb0_ff;
   assign prod_b = u0_ff * u0_ff;
   assign a1_in  = (cc0_ff.shift34 ? $signed(prod_a[QB+4+QW-1:QB+4])
                                   : $signed(prod_a[QB+QW-1:QB])) + kadd0_ff;
   assign b1_in  = $signed(prod_b[QB+QW-1:QB]);

   assign sel2   = cc1_ff.sq2 ? b1_ff : a1_ff;
   assign prod_2 = b1_ff * sel2;
   assign c2_in  = cc1_ff.mul2 ? $signed(prod_2[QB+QW-1:QB]) : a1_ff;

   assign prod_3 = c2_ff * u2_ff;
   assign d3_in  = cc2_ff.mul3 ? $signed(prod_3[QB+QW-1:QB]) : c2_ff;

   assign dterm  = cc3_ff.inv ? Q_ONE - d3_ff : d3_ff;
   assign offq   = {{(QW-QB-2){1'b0}}, cc3_ff.off, {QB{1'b0}}};
   always_comb begin
      qval_type t;
      t     = dterm + offq;
      f4_in = cc3_ff.halve ? (t >>> 1) : t;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (advance) begin
         vld0_ff <= valid_i;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ictl0_ff <= ctl_i;
         cc0_ff   <= cc0_in;
         opa0_ff  <= opa0_in;
         opb0_ff  <= opb0_in;
         u0_ff    <= u0_in;
         kadd0_ff <= kadd0_in;
         ictl1_ff <= ictl0_ff;
         cc1_ff   <= cc0_ff;
         u1_ff    <= u0_ff;
         a1_ff    <= a1_in;
         b1_ff    <= b1_in;
         ictl2_ff <= ictl1_ff;
         cc2_ff   <= cc1_ff;
         u2_ff    <= u1_ff;
         c2_ff    <= c2_in;
         ictl3_ff <= ictl2_ff;
         cc3_ff   <= cc2_ff;
         d3_ff    <= d3_in;
         ictl4_ff <= ictl3_ff;
         f4_ff    <= f4_in;
      end
   end

   assign valid_o = vld4_ff;
   assign ctl_o   = ictl4_ff;
   assign f_o     = f4_ff;
endmodule
`default_nettype wire

// ===== design/ece_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ece_scale (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               valid_i,
   input  ece_pkg::item_ctl_type              ctl_i,
   input  ece_pkg::qval_type                  f_i,
   output logic                               valid_o,
   output logic signed [ece_pkg::OFS_W-1:0]   offset_o,
   output logic                               bad_mode_o,
   output logic                               zero_dur_o
);
   import ece_pkg::*;

   localparam int MW = CHG_W + QW;
   localparam int RW = MW + 1 - QB;

   logic                   vld0_ff;
   item_ctl_type           ictl0_ff;
   logic signed [MW-1:0]   prod_ff, prod_in;
   logic signed [MW:0]     sum;
   logic signed [RW-1:0]   r;
   logic                   valid_ff;
   logic signed [OFS_W-1:0] offset_ff, offset_in;
   logic                   bad_ff, zd_ff;

   assign prod_in = ctl_i.change * f_i;

   // round half up, then clip to 32 bits
   assign sum = {prod_ff[MW-1], prod_ff} + {{(MW-QB+1){1'b0}}, 1'b1, {(QB-1){1'b0}}};
   assign r   = $signed(sum[MW:QB]);

   always_comb begin
      if (ictl0_ff.zero_dur) begin
         offset_in = OFS_W'(ictl0_ff.change);
      end else if (r[RW-1:OFS_W-1] == '0 || r[RW-1:OFS_W-1] == '1) begin
         offset_in = r[OFS_W-1:0];
      end else if (r[RW-1]) begin
         offset_in = {1'b1, {(OFS_W-1){1'b0}}};
      end else begin
         offset_in = {1'b0, {(OFS_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         vld0_ff  <= valid_i;
         valid_ff <= vld0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ictl0_ff  <= ctl_i;
         prod_ff   <= prod_in;
         offset_ff <= offset_in;
         bad_ff    <= ictl0_ff.func > MD_QUINT_INOUT;
         zd_ff     <= ictl0_ff.zero_dur;
      end
   end

   assign valid_o    = valid_ff;
   assign offset_o   = offset_ff;
   assign bad_mode_o = bad_ff;
   assign zero_dur_o = zd_ff;
endmodule
`default_nettype wire

// ===== design/easing_curve_evaluator_unit.sv =====
// Throughput: one word per cycle, set by the 16-stage pipeline: an entry
// register, eight divider stages of four quotient bits, five curve stages and
// two scaling stages. All stages hold together while a response waits.
// Reset is synchronous; it clears the valid bits, data registers keep state.
`timescale 1ns / 1ps
`default_nettype none
module easing_curve_evaluator_unit #(
   parameter int TIME_BITS = ece_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ece_req_if.sink     req_ch,
   ece_rsp_if.source   rsp_ch
);
   import ece_pkg::*;

   logic                  advance;
   logic                  ent_vld_ff;
   item_ctl_type          ent_ctl_ff, ent_ctl_in;
   logic [TIME_BITS-1:0]  ent_te_ff, ent_te_in, ent_du_ff;

   logic                  dv_vld [DIV_STAGES+1];
   item_ctl_type          dv_ctl [DIV_STAGES+1];
   logic [TIME_BITS:0]    dv_rem [DIV_STAGES+1];
   logic [TIME_BITS-1:0]  dv_den [DIV_STAGES+1];
   logic [QUO_BITS-1:0]   dv_quo [DIV_STAGES+1];

   logic                  crv_vld;
   item_ctl_type          crv_ctl;
   qval_type              crv_f;

   assign advance      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = advance;

   // clamp elapsed to duration
   assign ent_te_in = (req_ch.elapsed < req_ch.duration) ? req_ch.elapsed : req_ch.duration;
   always_comb begin
      ent_ctl_in.func     = req_ch.func;
      ent_ctl_in.first    = {ent_te_in, 1'b0} < {1'b0, req_ch.duration};
      ent_ctl_in.zero_dur = req_ch.duration == '0;
      ent_ctl_in.change   = req_ch.change;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
      end else if (advance) begin
         ent_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ent_ctl_ff <= ent_ctl_in;
         ent_te_ff  <= ent_te_in;
         ent_du_ff  <= req_ch.duration;
      end
   end

   assign dv_vld[0] = ent_vld_ff;
   assign dv_ctl[0] = ent_ctl_ff;
   assign dv_rem[0] = {1'b0, ent_te_ff};
   assign dv_den[0] = ent_du_ff;
   assign dv_quo[0] = '0;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      ece_div_stage #(.TIME_BITS(TIME_BITS)) u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (dv_vld[g]),
         .ctl_i   (dv_ctl[g]),
         .rem_i   (dv_rem[g]),
         .den_i   (dv_den[g]),
         .quo_i   (dv_quo[g]),
         .valid_o (dv_vld[g+1]),
         .ctl_o   (dv_ctl[g+1]),
         .rem_o   (dv_rem[g+1]),
         .den_o   (dv_den[g+1]),
         .quo_o   (dv_quo[g+1])
      );
   end

   ece_curve u_curve (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .valid_i (dv_vld[DIV_STAGES]),
      .ctl_i   (dv_ctl[DIV_STAGES]),
      .quo_i   (dv_quo[DIV_STAGES]),
      .valid_o (crv_vld),
      .ctl_o   (crv_ctl),
      .f_o     (crv_f)
   );

   ece_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .valid_i    (crv_vld),
      .ctl_i      (crv_ctl),
      .f_i        (crv_f),
      .valid_o    (rsp_ch.valid),
      .offset_o   (rsp_ch.offset),
      .bad_mode_o (rsp_ch.bad_mode),
      .zero_dur_o (rsp_ch.zero_duration)
   );
endmodule
`default_nettype wire

// ===== design/ece_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ece_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_offset,
   input logic               rsp_bad_mode,
   input logic               rsp_zero_duration
);
   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid after reset");

   // an empty output stage never blocks intake
   a_free_accept: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request not ready while output stage empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_offset) && $stable(rsp_bad_mode)
                                  && $stable(rsp_zero_duration))
      else $error("response word changed while stalled");

   // intake and output stall together
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("intake ran during output stall");
endmodule

bind easing_curve_evaluator_unit ece_checker u_ece_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_offset        (rsp_ch.offset),
   .rsp_bad_mode      (rsp_ch.bad_mode),
   .rsp_zero_duration (rsp_ch.zero_duration)
);
`default_nettype wire

// ===== dv/easing_curve_evaluator_unit_test.sv =====
`timescale 1ns / 1ps
module easing_curve_evaluator_unit_test;
   import ece_pkg::*;

   typedef struct packed {
      logic [3:0]         func;
      logic [15:0]        elapsed;
      logic [15:0]        duration;
      logic signed [30:0] change;
   } ease_req_type;

   typedef struct packed {
      logic signed [31:0] offset;
      logic               bad_mode;
      logic               zero_duration;
   } ease_rsp_type;

   localparam longint ONE = 64'sd1 << 30;
   localparam longint SB  = (64'sd170158 * ONE + 64'sd50000) / 64'sd100000;
   localparam longint SB2 = (64'sd259490950 * ONE + 64'sd50000000) / 64'sd100000000;
   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ece_req_if req_ch ();
   ece_rsp_if rsp_ch ();

   easing_curve_evaluator_unit u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always #5 clock = ~clock;

   ease_rsp_type expected_offsets[$];
   int  error_count = 0;
   bit  src_idle_on = 1'b1;
   bit  snk_idle_on = 1'b1;
   int  hold_off_cycles = 0;
   int  quiet_cycles = 0;

   function automatic longint fshr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return fshr(a * b, 30);
   endfunction

   function automatic longint pow5(longint u);
      longint u2;
      u2 = qmul(u, u);
      return qmul(qmul(u2, u2), u);
   endfunction

   function automatic longint back_core(longint u, longint k, bit neg);
      longint a;
      a = qmul(k + ONE, u) + (neg ? -k : k);
      return qmul(qmul(u, u), a);
   endfunction

   function automatic longint bounce_out(longint p);
      longint e, q, k;
      longint unsigned a;
      e = 11 * p;
      if (e < 4 * ONE) begin
         q = e; k = 0;
      end else if (e < 8 * ONE) begin
         q = e - 6 * ONE; k = 3 * ONE / 4;
      end else if (e < 10 * ONE) begin
         q = e - 9 * ONE; k = 15 * ONE / 16;
      end else begin
         q = e - 21 * ONE / 2; k = 63 * ONE / 64;
      end
      a = (q < 0) ? -q : q;
      return longint'((a * a) >> 34) + k;
   endfunction

   function automatic longint bounce_in(longint p);
      return ONE - bounce_out(ONE - p);
   endfunction

   function automatic longint curve_value(logic [3:0] m, longint p, longint x, bit first);
      longint y;
      case (m)
         MD_BACK_IN:    return back_core(p, SB, 1'b1);
         MD_BACK_OUT:   return back_core(p - ONE, SB, 1'b0) + ONE;
         MD_BACK_INOUT: begin
            if (first) return fshr(back_core(x, SB2, 1'b1), 1);
            return fshr(back_core(x - 2 * ONE, SB2, 1'b0) + 2 * ONE, 1);
         end
         MD_BOUNCE_IN:  return bounce_in(p);
         MD_BOUNCE_OUT: return bounce_out(p);
         MD_BOUNCE_INOUT: begin
            if (first) return fshr(bounce_in(x), 1);
            return fshr(bounce_out(x - ONE), 1) + ONE / 2;
         end
         MD_QUAD_IN:    return qmul(p, p);
         MD_QUAD_OUT:   return qmul(p, 2 * ONE - p);
         MD_QUAD_INOUT: begin
            if (first) return fshr(qmul(x, x), 1);
            y = x - ONE;
            return fshr(ONE + qmul(y, 2 * ONE - y), 1);
         end
         MD_QUINT_IN:   return pow5(p);
         MD_QUINT_OUT:  return pow5(p - ONE) + ONE;
         MD_QUINT_INOUT: begin
            if (first) return fshr(pow5(x), 1);
            return fshr(pow5(x - 2 * ONE) + 2 * ONE, 1);
         end
         default:       return p;
      endcase
   endfunction

   function automatic ease_rsp_type eased_offset(ease_req_type w);
      ease_rsp_type r;
      longint unsigned te, du;
      longint chg, p, x, f, v;
      chg = longint'(w.change);
      du = w.duration;
      if (du == 0) begin
         v = chg;
         r.zero_duration = 1'b1;
      end else begin
         te = (w.elapsed < w.duration) ? w.elapsed : w.duration;
         p = longint'((te << 30) / du);
         x = longint'(((te * 2) << 30) / du);
         f = curve_value(w.func, p, x, (te * 2) < du);
         v = fshr(chg * f + ONE / 2, 30);
         r.zero_duration = 1'b0;
      end
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      r.offset = v[31:0];
      r.bad_mode = (w.func > MD_QUINT_INOUT);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic idle_gap(bit enable);
      if (enable && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // send one word; expectation is queued at acceptance
   task automatic send_word(ease_req_type w);
      req_ch.valid    <= 1'b1;
      req_ch.func     <= w.func;
      req_ch.elapsed  <= w.elapsed;
      req_ch.duration <= w.duration;
      req_ch.change   <= w.change;
      do @(posedge clock); while (!req_ch.ready);
      expected_offsets.insert(expected_offsets.size(), eased_offset(w));
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic release_source();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic ease_req_type rand_word(bit small_times);
      ease_req_type w;
      w.func = 4'($urandom_range(0, 15));
      if (small_times && $urandom_range(0, 1)) begin
         w.duration = 16'($urandom_range(0, 40));
         w.elapsed  = 16'($urandom_range(0, 45));
      end else begin
         w.duration = 16'($urandom);
         w.elapsed  = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, w.duration));
      end
      if ($urandom_range(0, 9) == 0) w.duration = 16'd0;
      case ($urandom_range(0, 5))
         0:       w.change = $urandom_range(0, 1) ? 31'h3FFFFFFF : 31'h40000000;
         1:       w.change = 31'($signed($urandom_range(0, 200000)) - 100000);
         default: w.change = 31'($urandom);
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      ease_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_offsets.size() == 0) begin
               report_mismatch("unexpected word", rsp_ch.offset, 0);
            end else begin
               want = expected_offsets.pop_front();
               if (rsp_ch.offset !== want.offset)
                  report_mismatch("offset", rsp_ch.offset, want.offset);
               if (rsp_ch.bad_mode !== want.bad_mode)
                  report_mismatch("bad_mode", rsp_ch.bad_mode, want.bad_mode);
               if (rsp_ch.zero_duration !== want.zero_duration)
                  report_mismatch("zero_duration", rsp_ch.zero_duration,
                                  want.zero_duration);
            end
         end
         // hold off for a counted stretch, else stall at random cycles while enabled, else stay ready
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ch.ready <= 1'b0;
         end else if (snk_idle_on) begin
            rsp_ch.ready <= ($urandom_range(0, 4) != 0);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("easing_curve_evaluator_unit_test NOT OK");
         $finish;
      end
   end

   task automatic drain_all();
      while (expected_offsets.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      ease_req_type w;
      for (int m = 0; m < 16; m++) begin
         w.func = 4'(m); w.duration = 16'd100; w.elapsed = 16'(37 + m);
         w.change = 31'sd6553600;
         send_word(w);
      end
      w = '{MD_LINEAR, 16'hFFFF, 16'hFFFF, 31'h3FFFFFFF};     send_word(w);
      w = '{MD_BACK_INOUT, 16'hFFFF, 16'd0, 31'h40000000};    send_word(w);
      w = '{4'd15, 16'd5, 16'd0, 31'sd12345};                 send_word(w);
      w = '{MD_BACK_OUT, 16'd900, 16'd1000, 31'h3FFFFFFF};    send_word(w);
      w = '{MD_BACK_IN, 16'd200, 16'd1000, 31'h40000000};     send_word(w);
      w = '{MD_QUAD_INOUT, 16'd50, 16'd100, 31'sd65536};      send_word(w);
      w = '{MD_BOUNCE_INOUT, 16'd0, 16'd1, 31'sd65536};       send_word(w);
      w = '{MD_QUINT_OUT, 16'hFFFF, 16'd1, -31'sd65536};      send_word(w);
      release_source();
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 60;
      for (int i = 0; i < 40; i++) send_word(rand_word(1'b1));
      release_source();
      drain_all();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) send_word(rand_word(1'b1));
      release_source();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = '0;
      req_ch.elapsed = '0;
      req_ch.duration = '0;
      req_ch.change = '0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain_all();
      test_backpressure();
      test_random(1200);
      src_idle_on = 1'b0;
      snk_idle_on = 1'b0;
      test_random(300);
      drain_all();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("easing_curve_evaluator_unit_test OK");
      else
         $display("easing_curve_evaluator_unit_test NOT OK");
      $finish;
   end
endmodule

// ===== sim.f =====
design/ece_pkg.sv
design/ece_req_if.sv
design/ece_rsp_if.sv
design/ece_div_stage.sv
design/ece_curve.sv
design/ece_scale.sv
design/easing_curve_evaluator_unit.sv
design/ece_checker.sv
dv/easing_curve_evaluator_unit_test.sv
